FILE: hdl/extended_input_capture_timer_top_assert.svh
// assertion macros shared by the capture timer modules
`ifndef EXTENDED_INPUT_CAPTURE_TIMER_TOP_ASSERT_SVH
`define EXTENDED_INPUT_CAPTURE_TIMER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define EIC_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define EIC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/eic_pkg.sv
// types and constants of the extended input capture timer
package eic_pkg;

    localparam int NUM_CH  = 3;
    localparam int PHYS_CH = 3;
    localparam int LIVE_CH = (NUM_CH < PHYS_CH) ? NUM_CH : PHYS_CH;

    localparam int TIME_W   = 32;
    localparam int PRE_W    = 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int EDGE_W   = 2;

    localparam int EDGE_RISE_BIT = 0;
    localparam int EDGE_FALL_BIT = 1;

    localparam logic [EDGE_W-1:0] EDGE_RESET = 2'd1;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ARM  = 2'd1,
        CMD_STOP = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        REG_EDGE_CH0 = 2'd0,
        REG_EDGE_CH1 = 2'd1,
        REG_EDGE_CH2 = 2'd2,
        REG_PRESCALE = 2'd3
    } reg_idx_e;

    typedef struct packed {
        cmd_e              cmd;
        logic [1:0]        channel;
        logic              use_input_b;
        logic [PHYS_CH-1:0] levels_a;
        logic [PHYS_CH-1:0] levels_b;
    } eic_in_t;

    typedef struct packed {
        logic [PHYS_CH-1:0] capture_mask;
        logic [TIME_W-1:0]  capture_time;
        logic [TIME_W-1:0]  current_time;
    } eic_out_t;

    typedef struct packed {
        logic [PHYS_CH-1:0][EDGE_W-1:0] edge_mode;
        logic [1:0]                     prescale_log2;
    } eic_cfg_t;

endpackage

FILE: hdl/eic_regs.sv
// configuration register file behind the apb-style port
module eic_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eic_pkg::ADDR_W-1:0]  paddr,
    input  logic [eic_pkg::DATA_W-1:0]  pwdata,
    output logic [eic_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output eic_pkg::eic_cfg_t           cfg
);
    import eic_pkg::*;

    eic_cfg_t cfg_reg;
    eic_cfg_t cfg_next;
    reg_idx_e idx;
    logic     wr_en;

    assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_EDGE_CH0: cfg_next.edge_mode[0]  = pwdata[EDGE_W-1:0];
                REG_EDGE_CH1: cfg_next.edge_mode[1]  = pwdata[EDGE_W-1:0];
                REG_EDGE_CH2: cfg_next.edge_mode[2]  = pwdata[EDGE_W-1:0];
                REG_PRESCALE: cfg_next.prescale_log2 = pwdata[1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EDGE_CH0: prdata = DATA_W'(cfg_reg.edge_mode[0]);
            REG_EDGE_CH1: prdata = DATA_W'(cfg_reg.edge_mode[1]);
            REG_EDGE_CH2: prdata = DATA_W'(cfg_reg.edge_mode[2]);
            REG_PRESCALE: prdata = DATA_W'(cfg_reg.prescale_log2);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_mode     <= {PHYS_CH{EDGE_RESET}};
            cfg_reg.prescale_log2 <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/eic_core.sv
// timer state, edge detection and per-item result
module eic_core (
    input  logic               clk,
    input  logic               rst_n,
    input  eic_pkg::eic_cfg_t  cfg,
    input  logic               acc,
    input  eic_pkg::eic_in_t   item,
    output eic_pkg::eic_out_t  res
);
    import eic_pkg::*;

    logic [TIME_W-1:0]    time_count_reg, time_count_next;
    logic [PRE_W-1:0]     prescale_count_reg, prescale_count_next;
    logic [PHYS_CH-1:0]   armed_reg, armed_next;
    logic [PHYS_CH-1:0]   source_is_b_reg, source_is_b_next;
    logic [2*PHYS_CH-1:0] last_levels_reg, last_levels_next;

    logic [PHYS_CH-1:0]   now_lvl;
    logic [PHYS_CH-1:0]   prev_lvl;
    logic [PHYS_CH-1:0]   hit;
    logic [PRE_W:0]       pre_inc;
    logic [PRE_W:0]       pre_lim;
    logic                 pre_fire;
    logic                 ch_ok;

    // selected input level now and on the previous tick
    always_comb
    begin
        now_lvl  = '0;
        prev_lvl = '0;
        hit      = '0;
        for (int i = 0; i < PHYS_CH; i++)
        begin
            if (i < LIVE_CH)
            begin
                now_lvl[i]  = source_is_b_reg[i] ? item.levels_b[i] : item.levels_a[i];
                prev_lvl[i] = source_is_b_reg[i] ? last_levels_reg[i + PHYS_CH]
                                                 : last_levels_reg[i];
                hit[i] = armed_reg[i] &&
                         ((cfg.edge_mode[i][EDGE_RISE_BIT] && !prev_lvl[i] && now_lvl[i]) ||
                          (cfg.edge_mode[i][EDGE_FALL_BIT] && prev_lvl[i] && !now_lvl[i]));
            end
        end
    end

    assign pre_inc  = {1'b0, prescale_count_reg} + (PRE_W+1)'(1);
    assign pre_lim  = (PRE_W+1)'(1) << cfg.prescale_log2;
    assign pre_fire = (pre_inc >= pre_lim);
    assign ch_ok    = (int'(item.channel) < LIVE_CH);

    always_comb
    begin
        time_count_next     = time_count_reg;
        prescale_count_next = prescale_count_reg;
        armed_next          = armed_reg;
        source_is_b_next    = source_is_b_reg;
        last_levels_next    = last_levels_reg;
        res.capture_mask    = '0;
        res.capture_time    = '0;
        unique case (item.cmd)
            CMD_TICK:
            begin
                res.capture_mask = hit;
                if (hit != '0)
                begin
                    res.capture_time = time_count_reg;
                end
                last_levels_next = {item.levels_b, item.levels_a};
                if (pre_fire)
                begin
                    prescale_count_next = '0;
                    time_count_next     = time_count_reg + TIME_W'(1);
                end
                else
                begin
                    prescale_count_next = pre_inc[PRE_W-1:0];
                end
            end
            CMD_ARM:
            begin
                if (ch_ok)
                begin
                    armed_next[item.channel]       = 1'b1;
                    source_is_b_next[item.channel] = item.use_input_b;
                end
            end
            CMD_STOP:
            begin
                if (ch_ok)
                begin
                    armed_next[item.channel] = 1'b0;
                end
            end
            CMD_RSVD:
            begin
            end
        endcase
        res.current_time = time_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg     <= '0;
            prescale_count_reg <= '0;
            armed_reg          <= '0;
            source_is_b_reg    <= '0;
            last_levels_reg    <= '0;
        end
        else if (acc)
        begin
            time_count_reg     <= time_count_next;
            prescale_count_reg <= prescale_count_next;
            armed_reg          <= armed_next;
            source_is_b_reg    <= source_is_b_next;
            last_levels_reg    <= last_levels_next;
        end
    end

`include "extended_input_capture_timer_top_assert.svh"

    // only ticks move the counter
    `EIC_ASSERT_NEXT(a_no_count_off_tick, clk, rst_n, acc && item.cmd != CMD_TICK, time_count_reg == $past(time_count_reg))
    // a channel that is stopped never captures
    `EIC_ASSERT_SAME(a_mask_armed_only, clk, rst_n, acc, (res.capture_mask & ~armed_reg) == '0)
    // no capture means a zero timestamp
    `EIC_ASSERT_SAME(a_zero_time_no_hit, clk, rst_n, acc && res.capture_mask == '0, res.capture_time == '0)
    // prescaler never runs past its period
    `EIC_ASSERT_NEXT(a_prescale_bound, clk, rst_n, acc && item.cmd == CMD_TICK, {1'b0, prescale_count_reg} < ((PRE_W+1)'(1) << $past(cfg.prescale_log2)) || prescale_count_reg == $past(prescale_count_reg) + PRE_W'(1))

endmodule

FILE: hdl/eic_out_stage.sv
// result register between the core and the output channel
module eic_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  eic_pkg::eic_out_t  res,
    output logic               can_load,
    output logic               res_valid,
    input  logic               res_ready,
    output eic_pkg::eic_out_t  res_item
);
    import eic_pkg::*;

    logic     valid_reg;
    eic_out_t data_reg;

    // a new item may enter while the held result leaves in the same cycle
    assign can_load  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_item  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

`include "extended_input_capture_timer_top_assert.svh"

    // every loaded item shows up as a result next cycle
    `EIC_ASSERT_NEXT(a_load_shows, clk, rst_n, load, valid_reg)
    // back-pressure only while a result is held
    `EIC_ASSERT_SAME(a_stall_only_full, clk, rst_n, !can_load, valid_reg && !res_ready)
    // a held result that is not taken is kept
    `EIC_ASSERT_NEXT(a_hold_unloaded, clk, rst_n, valid_reg && !res_ready, valid_reg && data_reg == $past(data_reg))

endmodule

FILE: hdl/extended_input_capture_timer_top.sv
// an accepted item's result is registered and appears on res_valid/res_item in the next cycle
// throughput: one item per cycle; cmd_ready drops only while a held result is not taken
// each item is processed by one level of logic between the timer state and the result register
// reset (rst_n low, asynchronous): counter, prescaler, last levels cleared, all channels
// stopped on input A, edge modes rising, prescale divide by one, no result pending
module extended_input_capture_timer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  eic_pkg::eic_in_t            cmd_item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output eic_pkg::eic_out_t           res_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eic_pkg::ADDR_W-1:0]  paddr,
    input  logic [eic_pkg::DATA_W-1:0]  pwdata,
    output logic [eic_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import eic_pkg::*;

    eic_cfg_t cfg;
    eic_out_t core_res;
    logic     acc;
    logic     can_load;

    assign cmd_ready = can_load;
    assign acc       = cmd_valid && can_load;

    eic_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eic_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .acc   (acc),
        .item  (cmd_item),
        .res   (core_res)
    );

    eic_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (acc),
        .res       (core_res),
        .can_load  (can_load),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

FILE: bench/eic_checker.sv
// checker for the capture timer: predicts every result and compares it with the block's output
module eic_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_ready,
    input  eic_pkg::eic_in_t            cmd_item,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  eic_pkg::eic_out_t           res_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [eic_pkg::ADDR_W-1:0]  paddr,
    input  logic [eic_pkg::DATA_W-1:0]  pwdata,
    output int                          fail_count,
    output int                          outstanding,
    output int                          results_checked,
    output int                          capture_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    import eic_pkg::*;

    // predicted timer state
    logic [TIME_W-1:0]  time_count;
    logic [PRE_W-1:0]   pre_count;
    logic               armed [PHYS_CH];
    logic               src_b [PHYS_CH];
    logic [5:0]         prev_levels;
    logic [EDGE_W-1:0]  edge_mode [PHYS_CH];
    logic [1:0]         prescale_log2;

    eic_out_t reports_due [$];
    int mismatches = 0;
    int checked = 0;
    int hits = 0;

    function automatic eic_out_t capture_step(input eic_in_t it);
        eic_out_t r;
        logic now_lvl;
        logic prev_lvl;
        r = '0;
        case (it.cmd)
            CMD_TICK:
            begin
                for (int i = 0; i < LIVE_CH; i++)
                begin
                    if (armed[i])
                    begin
                        now_lvl  = src_b[i] ? it.levels_b[i] : it.levels_a[i];
                        prev_lvl = src_b[i] ? prev_levels[i + 3] : prev_levels[i];
                        if ((edge_mode[i][EDGE_RISE_BIT] && !prev_lvl && now_lvl) ||
                            (edge_mode[i][EDGE_FALL_BIT] && prev_lvl && !now_lvl))
                            r.capture_mask[i] = 1'b1;
                    end
                end
                if (r.capture_mask != '0)
                    r.capture_time = time_count;
                prev_levels = {it.levels_b, it.levels_a};
                // lowering the divider mid-count fires on the next tick
                if (int'(pre_count) + 1 >= (1 << prescale_log2))
                begin
                    pre_count  = '0;
                    time_count = time_count + 1'b1;
                end
                else
                    pre_count = pre_count + 1'b1;
            end
            CMD_ARM:
            begin
                if (it.channel < LIVE_CH)
                begin
                    armed[it.channel] = 1'b1;
                    src_b[it.channel] = it.use_input_b;
                end
            end
            CMD_STOP:
            begin
                if (it.channel < LIVE_CH)
                    armed[it.channel] = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.current_time = time_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        eic_out_t want;
        reg_idx_e idx;
        if (!rst_n)
        begin
            time_count    = '0;
            pre_count     = '0;
            prev_levels   = '0;
            prescale_log2 = '0;
            for (int i = 0; i < PHYS_CH; i++)
            begin
                armed[i]     = 1'b0;
                src_b[i]     = 1'b0;
                edge_mode[i] = EDGE_RESET;
            end
            reports_due.delete();
        end
        else
        begin
            // result side first so that a result cannot match an item of the same edge
            if (res_valid && res_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    checked++;
                    if (want.capture_mask != '0)
                        hits++;
                    if (res_item.capture_mask !== want.capture_mask)
                    begin
                        $error("capture_mask: expected %0d, got %0d",
                               want.capture_mask, res_item.capture_mask);
                        mismatches++;
                    end
                    if (res_item.capture_time !== want.capture_time)
                    begin
                        $error("capture_time: expected %0d, got %0d",
                               want.capture_time, res_item.capture_time);
                        mismatches++;
                    end
                    if (res_item.current_time !== want.current_time)
                    begin
                        $error("current_time: expected %0d, got %0d",
                               want.current_time, res_item.current_time);
                        mismatches++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                reports_due.push_back(capture_step(cmd_item));
            if (psel && penable && pwrite && pready)
            begin
                idx = reg_idx_e'(paddr[ADDR_W-1:2]);
                if (idx == REG_PRESCALE)
                    prescale_log2 = pwdata[1:0];
                else
                    edge_mode[idx] = pwdata[EDGE_W-1:0];
            end
        end
        fail_count      <= mismatches;
        outstanding     <= reports_due.size();
        results_checked <= checked;
        capture_hits    <= hits;
    end

endmodule

FILE: bench/tb_extended_input_capture_timer_top.sv
// testbench top for the capture timer: clock, reset, stimulus, register writes and verdict
module tb_extended_input_capture_timer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eic_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS   = 105;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_ready;
    eic_in_t             cmd_item;
    logic                res_valid;
    logic                res_ready;
    eic_out_t            res_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int fail_count;
    int outstanding;
    int results_checked;
    int capture_hits;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;

    extended_input_capture_timer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    eic_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd_item        (cmd_item),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_item        (res_item),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .capture_hits    (capture_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic eic_in_t make_item(input cmd_e c, input logic [1:0] ch,
                                          input logic use_b, input logic [2:0] la,
                                          input logic [2:0] lb);
        eic_in_t it;
        it.cmd         = c;
        it.channel     = ch;
        it.use_input_b = use_b;
        it.levels_a    = la;
        it.levels_b    = lb;
        return it;
    endfunction

    task automatic send_item(input eic_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // waits until every result is in, then lets the pipeline go quiet
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_e idx, input logic [1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [1:0] m0, input logic [1:0] m1,
                             input logic [1:0] m2, input logic [1:0] pre);
        write_reg(REG_EDGE_CH0, m0);
        write_reg(REG_EDGE_CH1, m1);
        write_reg(REG_EDGE_CH2, m2);
        write_reg(REG_PRESCALE, pre);
    endtask

    initial
    begin
        eic_in_t it;
        int pick;
        int useful;
        cmd_valid <= 1'b0;
        cmd_item  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rising edges, no division
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(CMD_ARM,  2'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(CMD_ARM,  2'd1, 1'b1, 3'd0, 3'd0));
        send_item(make_item(CMD_ARM,  2'd2, 1'b0, 3'd0, 3'd0));
        // channel beyond the channel count is ignored
        send_item(make_item(CMD_ARM,  2'd3, 1'b1, 3'd0, 3'd0));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd7, 3'd7));
        // unused command changes nothing
        send_item(make_item(CMD_RSVD, 2'd3, 1'b1, 3'd5, 3'd2));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd0, 3'd0));
        drain();

        // falling, both and disabled edge modes, slowest prescaler
        write_all(2'd2, 2'd3, 2'd0, 2'd3);
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd7, 3'd7));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd2, 3'd5));
        // rearm onto input b: compares against its last sampled level
        send_item(make_item(CMD_ARM,  2'd0, 1'b1, 3'd7, 3'd7));
        send_item(make_item(CMD_STOP, 2'd1, 1'b0, 3'd0, 3'd0));
        send_item(make_item(CMD_STOP, 2'd3, 1'b1, 3'd7, 3'd7));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd7, 3'd0));
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd7, 3'd7));
        drain();

        // dropping the divider mid-count fires on the next tick
        write_reg(REG_PRESCALE, 2'd0);
        send_item(make_item(CMD_TICK, 2'd0, 1'b0, 3'd0, 3'd2));
        send_item(make_item(CMD_TICK, 2'd0, 1'b1, 3'd5, 3'd2));

        for (int seg = 0; seg < 6; seg++)
        begin
            drain();
            case (seg)
                0: write_all(2'd1, 2'd2, 2'd3, 2'd0);
                1: write_all(2'd3, 2'd3, 2'd3, 2'd3);
                default: write_all(2'($urandom_range(1, 3)), 2'($urandom_range(1, 3)),
                                   2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)));
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 60;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 4)
                hold_req = 1'b1;
            useful = 0;
            while (useful < SEG_ITEMS)
            begin
                pick           = $urandom_range(99);
                it.use_input_b = 1'($urandom_range(1));
                it.levels_a    = 3'($urandom_range(7));
                it.levels_b    = 3'($urandom_range(7));
                it.channel     = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
                if (pick < 72)
                    it.cmd = CMD_TICK;
                else if (pick < 84)
                    it.cmd = CMD_ARM;
                else if (pick < 94)
                    it.cmd = CMD_STOP;
                else
                    it.cmd = CMD_RSVD;
                if (it.cmd == CMD_TICK ||
                    (it.cmd != CMD_RSVD && it.channel < LIVE_CH))
                    useful++;
                send_item(it);
            end
        end
        drain();

        $display("run covered directed edge, arm and prescaler cases plus %0d random %s",
                 6 * SEG_ITEMS, "ticks and in-range arm or stop items, with stray commands");
        $display("%0d results checked, %0d with captures, one %0d-cycle receiver hold-off",
                 results_checked, capture_hits, HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
